FILE: hw/rtl/rpv_pkg.sv
// Package for the vertex rotation and projection block: default widths, register
// indexes, the quarter-wave sine table and the degree-to-trig lookup functions.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package rpv_pkg;

  // Default widths of the parameterized datapath.
  localparam int COORD_BITS_DEF     = 12;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int SCREEN_BITS_DEF    = 11;

  // Fixed register widths.
  localparam int ANGLE_BITS  = 9;
  localparam int ZOOM_BITS   = 12;
  localparam int CENTER_BITS = 11;
  localparam int CFG_WIDTH   = 12;
  localparam int CFG_INDEX_BITS = 3;

  // Zoom is Q4.8.
  localparam int ZOOM_FRAC_BITS = 8;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_X  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_Y  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_Z  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZOOM     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = 3'd5;

  // Reset values of the registers.
  localparam logic [ANGLE_BITS-1:0]  ANGLE_X_RST  = 9'd45;
  localparam logic [ANGLE_BITS-1:0]  ANGLE_Y_RST  = 9'd30;
  localparam logic [ANGLE_BITS-1:0]  ANGLE_Z_RST  = 9'd0;
  localparam logic [ZOOM_BITS-1:0]   ZOOM_RST     = 12'd384;
  localparam logic [CENTER_BITS-1:0] CENTER_X_RST = 11'd240;
  localparam logic [CENTER_BITS-1:0] CENTER_Y_RST = 11'd136;

  // The table holds sin(0..90 degrees) in Q1.14.
  localparam int unsigned TABLE_FRAC = 14;
  localparam logic [14:0] QUARTER_SINE [0:90] = '{
        15'd0,   15'd286,   15'd572,   15'd857,  15'd1143,  15'd1428,  15'd1713,
     15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
     15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
     15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
     15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
     15'd9397,  15'd9630,  15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Table entry rescaled to f fraction bits: rounded down in precision, or shifted up.
  function automatic logic [31:0] quarter_scaled(logic [6:0] d, int unsigned f);
    logic [31:0] t;
    t = 32'(QUARTER_SINE[d]);
    if (f < TABLE_FRAC) begin
      t = (t + (32'd1 << (TABLE_FRAC - f - 1))) >> (TABLE_FRAC - f);
    end else if (f > TABLE_FRAC) begin
      t = t << (f - TABLE_FRAC);
    end
    return t;
  endfunction

  // Sine of a whole-degree angle with f fraction bits; angles of 360 and up wrap once.
  function automatic logic signed [31:0] sine_deg(logic [ANGLE_BITS-1:0] a, int unsigned f);
    logic [ANGLE_BITS-1:0] m;
    logic [ANGLE_BITS-1:0] d;
    logic                  neg;
    logic [31:0]           q;
    m   = (a >= 9'd360) ? a - 9'd360 : a;
    neg = 1'b0;
    if (m <= 9'd90) begin
      d = m;
    end else if (m <= 9'd180) begin
      d = 9'd180 - m;
    end else if (m <= 9'd270) begin
      d   = m - 9'd180;
      neg = 1'b1;
    end else begin
      d   = 9'd360 - m;
      neg = 1'b1;
    end
    q = quarter_scaled(d[6:0], f);
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // Cosine as the sine of the wrapped angle plus a quarter turn.
  function automatic logic signed [31:0] cosine_deg(logic [ANGLE_BITS-1:0] a, int unsigned f);
    logic [ANGLE_BITS-1:0] m;
    m = (a >= 9'd360) ? a - 9'd360 : a;
    return sine_deg(m + 9'd90, f);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rpv_trig.sv
// Registered sine and cosine of the three configured rotation angles.
// Depends on rpv_pkg for the quarter-wave table and lookup functions.
`timescale 1ns / 1ps
`default_nettype none

module rpv_trig import rpv_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic [ANGLE_BITS-1:0]         angle_x,
  input  wire logic [ANGLE_BITS-1:0]         angle_y,
  input  wire logic [ANGLE_BITS-1:0]         angle_z,
  output logic signed [TRIG_FRAC_BITS+1:0]   sin_x,
  output logic signed [TRIG_FRAC_BITS+1:0]   cos_x,
  output logic signed [TRIG_FRAC_BITS+1:0]   sin_y,
  output logic signed [TRIG_FRAC_BITS+1:0]   cos_y,
  output logic signed [TRIG_FRAC_BITS+1:0]   sin_z,
  output logic signed [TRIG_FRAC_BITS+1:0]   cos_z
);

  localparam int TW = TRIG_FRAC_BITS + 2;

  // The angle inputs are the next values of the angle registers, so the table
  // output changes at the same edge as the registers and a beat accepted right
  // after a write already sees the new angle.
  always_ff @(posedge clk) begin
    sin_x <= TW'(sine_deg(angle_x, TRIG_FRAC_BITS));
    cos_x <= TW'(cosine_deg(angle_x, TRIG_FRAC_BITS));
    sin_y <= TW'(sine_deg(angle_y, TRIG_FRAC_BITS));
    cos_y <= TW'(cosine_deg(angle_y, TRIG_FRAC_BITS));
    sin_z <= TW'(sine_deg(angle_z, TRIG_FRAC_BITS));
    cos_z <= TW'(cosine_deg(angle_z, TRIG_FRAC_BITS));
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rotate_project_vertex_unit.sv
// Top level of the vertex rotation and orthographic projection block.
// Depends on rpv_pkg and instantiates rpv_trig for the angle lookups.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one vertex per beat:
//   vertex_x, vertex_y, vertex_z, signed. The vertex is rotated about X, then Z,
//   then Y, scaled by the Q4.8 zoom, offset by the screen center and truncated.
//   The output channel (out_valid / out_stall) carries screen_x, screen_y and
//   the clamped flag, one beat for every input beat, in order.
//   Throughput is one vertex per cycle while the receiver does not stall, set
//   by the seven-stage multiply and round pipeline; every stage holds one vertex.
//   Configuration is written through cfg_we / cfg_index / cfg_data; the user
//   must write it only while the pipeline is empty, which the block does not
//   enforce. An index beyond the six registers is ignored.
//   Reset (rst, synchronous) empties the pipeline and loads the register
//   defaults. When the receiver stalls, the output beat holds and earlier
//   stages keep moving into empty slots; in_stall rises only once all seven
//   stages are full.
`timescale 1ns / 1ps
`default_nettype none

module rotate_project_vertex_unit import rpv_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  parameter int SCREEN_BITS    = SCREEN_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [CFG_WIDTH-1:0]          cfg_data,
  // vertex input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_BITS-1:0]  vertex_x,
  input  wire logic signed [COORD_BITS-1:0]  vertex_y,
  input  wire logic signed [COORD_BITS-1:0]  vertex_z,
  // screen output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [SCREEN_BITS-1:0]             screen_x,
  output logic [SCREEN_BITS-1:0]             screen_y,
  output logic                               clamped
);

  // Datapath widths.
  localparam int C  = COORD_BITS;
  localparam int F  = TRIG_FRAC_BITS;
  localparam int TW = F + 2;            // trig value, Q1.F signed
  localparam int W1 = C + F + 2;        // first rotation results, Q.F
  localparam int R  = C + 2*F + 5;      // second rotation sums, Q.2F
  localparam int W2 = C + F + 3;        // second rotation results, Q.F
  localparam int R3 = C + 2*F + 6;      // third rotation sums, Q.2F
  localparam int W3 = C + F + 4;        // third rotation result, Q.F
  localparam int ZW = ZOOM_BITS + 1;    // zoom as a signed operand
  localparam int SH = F + ZOOM_FRAC_BITS;
  localparam int SW = C + F + SCREEN_BITS + 10;
  localparam int QW = SW - SH;
  localparam int STAGES = 7;

  localparam logic signed [R-1:0]  HALF_R     = R'(64'd1 << (F - 1));
  localparam logic signed [R-1:0]  HALF_R_M1  = R'((64'd1 << (F - 1)) - 64'd1);
  localparam logic signed [R3-1:0] HALF_R3    = R3'(64'd1 << (F - 1));
  localparam logic signed [R3-1:0] HALF_R3_M1 = R3'((64'd1 << (F - 1)) - 64'd1);
  localparam logic signed [SW-1:0] TRUNC_BIAS = SW'((64'd1 << SH) - 64'd1);
  localparam logic signed [QW-1:0] Q_MAX      = QW'((64'd1 << SCREEN_BITS) - 64'd1);
  localparam logic [SCREEN_BITS-1:0] SCREEN_MAX = '1;

  // Configuration registers.
  logic [ANGLE_BITS-1:0]  angle_x;
  logic [ANGLE_BITS-1:0]  angle_y;
  logic [ANGLE_BITS-1:0]  angle_z;
  logic [ZOOM_BITS-1:0]   zoom_factor;
  logic [CENTER_BITS-1:0] center_x;
  logic [CENTER_BITS-1:0] center_y;
  logic [ANGLE_BITS-1:0]  angle_x_next;
  logic [ANGLE_BITS-1:0]  angle_y_next;
  logic [ANGLE_BITS-1:0]  angle_z_next;
  logic [ZOOM_BITS-1:0]   zoom_factor_next;
  logic [CENTER_BITS-1:0] center_x_next;
  logic [CENTER_BITS-1:0] center_y_next;

  // Next register values; the trig lookup reads the next angles as well.
  always_comb begin
    angle_x_next     = angle_x;
    angle_y_next     = angle_y;
    angle_z_next     = angle_z;
    zoom_factor_next = zoom_factor;
    center_x_next    = center_x;
    center_y_next    = center_y;
    if (rst) begin
      angle_x_next     = ANGLE_X_RST;
      angle_y_next     = ANGLE_Y_RST;
      angle_z_next     = ANGLE_Z_RST;
      zoom_factor_next = ZOOM_RST;
      center_x_next    = CENTER_X_RST;
      center_y_next    = CENTER_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANGLE_X:  angle_x_next     = cfg_data[ANGLE_BITS-1:0];
        REG_ANGLE_Y:  angle_y_next     = cfg_data[ANGLE_BITS-1:0];
        REG_ANGLE_Z:  angle_z_next     = cfg_data[ANGLE_BITS-1:0];
        REG_ZOOM:     zoom_factor_next = cfg_data[ZOOM_BITS-1:0];
        REG_CENTER_X: center_x_next    = cfg_data[CENTER_BITS-1:0];
        REG_CENTER_Y: center_y_next    = cfg_data[CENTER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    angle_x     <= angle_x_next;
    angle_y     <= angle_y_next;
    angle_z     <= angle_z_next;
    zoom_factor <= zoom_factor_next;
    center_x    <= center_x_next;
    center_y    <= center_y_next;
  end

  // Sine and cosine of the three angles.
  logic signed [TW-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

  rpv_trig #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .clk     (clk),
    .angle_x (angle_x_next),
    .angle_y (angle_y_next),
    .angle_z (angle_z_next),
    .sin_x   (sin_x),
    .cos_x   (cos_x),
    .sin_y   (sin_y),
    .cos_y   (cos_y),
    .sin_z   (sin_z),
    .cos_z   (cos_z)
  );

  // Stage handshake: a stage loads when it is empty or its content moves on.
  logic [STAGES:1] valid;
  logic [STAGES:1] load;

  always_comb begin
    load[STAGES] = !valid[STAGES] || !out_stall;
    for (int k = STAGES - 1; k >= 1; k--) begin
      load[k] = !valid[k] || load[k+1];
    end
  end

  assign in_stall  = !load[1];
  assign out_valid = valid[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[1]) begin
        valid[1] <= in_valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (load[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // Stage 1: rotation about X is exact, since the vertex has no fraction bits.
  logic signed [W1-1:0] s1_y1, s1_z1, s1_a, s1_b;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s1_y1 <= W1'(vertex_y) * W1'(cos_x) - W1'(vertex_z) * W1'(sin_x);
      s1_z1 <= W1'(vertex_y) * W1'(sin_x) + W1'(vertex_z) * W1'(cos_x);
      s1_a  <= W1'(vertex_x) * W1'(cos_z);
      s1_b  <= W1'(vertex_x) * W1'(sin_z);
    end
  end

  // Stage 2: products of the rotated y with the Z-angle terms.
  logic signed [R-1:0]  s2_ysz, s2_ycz;
  logic signed [W1-1:0] s2_a, s2_b, s2_z1;

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s2_ysz <= R'(s1_y1) * R'(sin_z);
      s2_ycz <= R'(s1_y1) * R'(cos_z);
      s2_a   <= s1_a;
      s2_b   <= s1_b;
      s2_z1  <= s1_z1;
    end
  end

  // Stage 3: finish rotation about Z, rounding half away from zero.
  logic signed [R-1:0] sum_x2, sum_y2, bias_x2, bias_y2;
  logic signed [W2-1:0] s3_x2, s3_y2;
  logic signed [W1-1:0] s3_z1;

  always_comb begin
    sum_x2  = (R'(s2_a) <<< F) - s2_ysz;
    sum_y2  = (R'(s2_b) <<< F) + s2_ycz;
    bias_x2 = sum_x2 + (sum_x2[R-1] ? HALF_R_M1 : HALF_R);
    bias_y2 = sum_y2 + (sum_y2[R-1] ? HALF_R_M1 : HALF_R);
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      s3_x2 <= W2'(bias_x2 >>> F);
      s3_y2 <= W2'(bias_y2 >>> F);
      s3_z1 <= s2_z1;
    end
  end

  // Stage 4: products for rotation about Y.
  logic signed [R3-1:0] s4_xcy, s4_zsy;
  logic signed [W2-1:0] s4_y2;

  always_ff @(posedge clk) begin
    if (load[4]) begin
      s4_xcy <= R3'(s3_x2) * R3'(cos_y);
      s4_zsy <= R3'(s3_z1) * R3'(sin_y);
      s4_y2  <= s3_y2;
    end
  end

  // Stage 5: finish rotation about Y for x.
  logic signed [R3-1:0] sum_x3, bias_x3;
  logic signed [W3-1:0] s5_x3;
  logic signed [W2-1:0] s5_y2;

  always_comb begin
    sum_x3  = s4_xcy - s4_zsy;
    bias_x3 = sum_x3 + (sum_x3[R3-1] ? HALF_R3_M1 : HALF_R3);
  end

  always_ff @(posedge clk) begin
    if (load[5]) begin
      s5_x3 <= W3'(bias_x3 >>> F);
      s5_y2 <= s4_y2;
    end
  end

  // Stage 6: zoom.
  logic signed [ZW-1:0] zoom_s;
  logic signed [SW-1:0] s6_px, s6_py;

  assign zoom_s = $signed({1'b0, zoom_factor});

  always_ff @(posedge clk) begin
    if (load[6]) begin
      s6_px <= SW'(s5_x3) * SW'(zoom_s);
      s6_py <= SW'(s5_y2) * SW'(zoom_s);
    end
  end

  // Stage 7: add the center, truncate toward zero and saturate.
  logic signed [SW-1:0] sum_sx, sum_sy;
  logic signed [QW-1:0] q_x, q_y;
  logic                 lo_x, hi_x, lo_y, hi_y;
  logic [SCREEN_BITS-1:0] screen_x_next, screen_y_next;

  always_comb begin
    sum_sx = s6_px + $signed(SW'(center_x) << SH);
    sum_sy = s6_py + $signed(SW'(center_y) << SH);
    q_x    = QW'((sum_sx[SW-1] ? sum_sx + TRUNC_BIAS : sum_sx) >>> SH);
    q_y    = QW'((sum_sy[SW-1] ? sum_sy + TRUNC_BIAS : sum_sy) >>> SH);
    lo_x   = q_x[QW-1];
    lo_y   = q_y[QW-1];
    hi_x   = !lo_x && (q_x > Q_MAX);
    hi_y   = !lo_y && (q_y > Q_MAX);
    if (lo_x) begin
      screen_x_next = '0;
    end else if (hi_x) begin
      screen_x_next = SCREEN_MAX;
    end else begin
      screen_x_next = q_x[SCREEN_BITS-1:0];
    end
    if (lo_y) begin
      screen_y_next = '0;
    end else if (hi_y) begin
      screen_y_next = SCREEN_MAX;
    end else begin
      screen_y_next = q_y[SCREEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load[7]) begin
      screen_x <= screen_x_next;
      screen_y <= screen_y_next;
      clamped  <= lo_x || hi_x || lo_y || hi_y;
    end
  end

  // A clamped beat has at least one coordinate at a screen edge.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && clamped) |->
      (screen_x == '0 || screen_x == SCREEN_MAX || screen_y == '0 || screen_y == SCREEN_MAX))
    else $error("clamped beat without a saturated coordinate");

  // The input is held back only when every stage is full and the output stalls.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&valid) && out_stall))
    else $error("input stalled while the pipeline has room");

  // An output beat taken with nothing behind it leaves the output empty.
  assert property (@(posedge clk) disable iff (rst)
    (valid[STAGES] && !out_stall && !valid[STAGES-1]) |=> !out_valid)
    else $error("output beat repeated");

endmodule

`default_nettype wire
